// ===== rtl/serial_rx_fifo_with_waiter_unit_defines.svh =====
// assertion macros shared by the serial receive fifo checker
// needs i_clk and i_rst_n in the scope where a macro is used
`ifndef SERIAL_RX_FIFO_WITH_WAITER_UNIT_DEFINES_SVH
`define SERIAL_RX_FIFO_WITH_WAITER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SRFW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SRFW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/srfw_pkg.sv =====
// shared types and constants of the serial receive fifo with waiter
// no dependencies
package srfw_pkg;

    // default ring size
    localparam int RING_DEPTH_DEF = 256;

    // character codes
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // request kinds
    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_ARM  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // request payload
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic [8:0] wait_size;
        logic [7:0] wait_char;
    } t_in;

    // result payload
    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       notify;
        logic [8:0] notify_count;
        logic [7:0] notify_char;
        logic       read_valid;
        logic [7:0] read_byte;
        logic [8:0] fill_count;
        logic       dropped;
    } t_out;

endpackage

// ===== rtl/srfw_ram.sv =====
// generic single-clock ram, one write port, one read port, registered read
// no dependencies
module srfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/serial_rx_fifo_with_waiter_unit.sv =====
// top level of the serial receive fifo with one-shot waiter
// depends on srfw_pkg and srfw_ram
//
//   channel   handshake                  payload
//   request   i_in_valid / o_in_ready    i_in  (srfw_pkg::t_in)
//   result    o_out_valid / i_out_ready  o_out (srfw_pkg::t_out)
//
// one request at a time; a read that pops a byte passes through S_RD before S_OUT,
// every other request goes straight to S_OUT; S_RD waits on the ring ram's registered read port.
// the result then sits in an output register while the next request is taken.
// i_rst_n is synchronous: clears pointers, count, waiter and handshake state;
// the ring contents need no clearing since only stored bytes are popped.
// a stalled result holds the output register; requests wait only behind it.
module serial_rx_fifo_with_waiter_unit #(
    parameter int RING_DEPTH = srfw_pkg::RING_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  srfw_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output srfw_pkg::t_out  o_out
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int XW = (CW > 9) ? CW : 9;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [PW-1:0]     r_wp, n_wp;
    logic [PW-1:0]     r_rp, n_rp;
    logic [CW-1:0]     r_count, n_count;
    logic              r_armed, n_armed;
    logic [8:0]        r_thr, n_thr;
    logic [7:0]        r_match, n_match;
    srfw_pkg::t_out    r_pend;
    srfw_pkg::t_out    r_out;
    logic              r_out_valid;

    srfw_pkg::t_out    res;
    logic              in_acc;
    logic              out_load;
    logic              ram_we;
    logic              ram_re;
    logic [7:0]        ram_rdata;
    logic [7:0]        rx_b;
    logic              ring_full;
    logic [PW-1:0]     wp_next;
    logic [PW-1:0]     rp_next;
    logic [XW-1:0]     cnt_x;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // byte translation and ring bookkeeping
    assign rx_b      = (i_in.rx_byte == srfw_pkg::CHAR_CR) ? srfw_pkg::CHAR_LF : i_in.rx_byte;
    assign ring_full = (r_count == CW'(RING_DEPTH));
    assign wp_next   = (r_wp == PW'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign rp_next   = (r_rp == PW'(RING_DEPTH - 1)) ? '0 : r_rp + 1'b1;

    // request decode and state update
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        n_armed = r_armed;
        n_thr   = r_thr;
        n_match = r_match;
        res     = '0;
        ram_we  = 1'b0;
        ram_re  = 1'b0;
        if (in_acc) begin
            unique case (i_in.kind)
                srfw_pkg::KIND_RX: begin
                    if (i_in.rx_byte != '0) begin
                        if (ring_full) begin
                            res.dropped = 1'b1;
                        end else begin
                            ram_we  = 1'b1;
                            n_wp    = wp_next;
                            n_count = r_count + 1'b1;
                        end
                        if (r_armed) begin
                            res.echo_valid = 1'b1;
                            res.echo_byte  = rx_b;
                            if (r_match != '0 && rx_b == r_match) begin
                                res.notify      = 1'b1;
                                res.notify_char = r_match;
                                n_armed = 1'b0;
                                n_thr   = '0;
                                n_match = '0;
                            end else if (XW'(n_count) >= XW'(r_thr)) begin
                                res.notify = 1'b1;
                                n_armed = 1'b0;
                                n_thr   = '0;
                                n_match = '0;
                            end
                        end
                    end
                end
                srfw_pkg::KIND_ARM: begin
                    if (i_in.wait_size != '0) begin
                        n_armed = 1'b1;
                        n_thr   = i_in.wait_size;
                        n_match = i_in.wait_char;
                    end else begin
                        n_armed = 1'b0;
                        n_thr   = '0;
                        n_match = '0;
                    end
                end
                srfw_pkg::KIND_READ: begin
                    if (r_count != '0) begin
                        res.read_valid = 1'b1;
                        ram_re  = 1'b1;
                        n_rp    = rp_next;
                        n_count = r_count - 1'b1;
                    end
                end
                default: ;
            endcase
        end
        cnt_x          = XW'(n_count);
        res.fill_count = cnt_x[8:0];
        if (res.notify) begin
            res.notify_count = cnt_x[8:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = ram_re ? S_RD : S_OUT;
                end
            end
            S_RD:  n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_count     <= '0;
            r_armed     <= 1'b0;
            r_thr       <= '0;
            r_match     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
            r_armed <= n_armed;
            r_thr   <= n_thr;
            r_match <= n_match;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pending result and output register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pend <= res;
        end else if (r_state == S_RD) begin
            r_pend.read_byte <= ram_rdata;
        end
        if (out_load) begin
            r_out <= r_pend;
        end
    end

    // ring storage
    srfw_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (rx_b),
        .i_re    (ram_re),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/srfw_checker.sv =====
// port-level checker for the serial receive fifo with waiter, plus its bind
// depends on srfw_pkg and serial_rx_fifo_with_waiter_unit_defines.svh
`include "serial_rx_fifo_with_waiter_unit_defines.svh"

module srfw_checker #(
    parameter int RING_DEPTH = srfw_pkg::RING_DEPTH_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input srfw_pkg::t_out i_out
);

    localparam int         XW       = ($clog2(RING_DEPTH + 1) > 9) ? $clog2(RING_DEPTH + 1) : 9;
    localparam logic [XW-1:0] FULL_X = XW'(RING_DEPTH);
    localparam logic [8:0] FULL_LOW = FULL_X[8:0];

    // a stalled result keeps its payload
    `SRFW_ASSERT_NEXT(a_out_hold,
        i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out),
        "result changed while stalled")

    // the waiter only fires on a byte it echoes
    `SRFW_ASSERT_NOW(a_notify_echo,
        i_out_valid && i_out.notify,
        i_out.echo_valid,
        "notify without echo")

    // a drop only happens with a full ring
    `SRFW_ASSERT_NOW(a_drop_full,
        i_out_valid && i_out.dropped,
        i_out.fill_count == FULL_LOW,
        "drop while ring not full")

    // echoed bytes are translated and never zero
    `SRFW_ASSERT_NOW(a_echo_byte,
        i_out_valid && i_out.echo_valid,
        i_out.echo_byte != srfw_pkg::CHAR_CR && i_out.echo_byte != 8'd0,
        "bad echoed byte")

endmodule

bind serial_rx_fifo_with_waiter_unit srfw_checker #(
    .RING_DEPTH (RING_DEPTH)
) u_srfw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out       (o_out)
);

// ===== dv/srfw_result_checker.sv =====
// result checker for the serial receive fifo with one-shot waiter
// depends on srfw_pkg; watches both channels, predicts each result and compares
module srfw_result_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  srfw_pkg::t_in   i_in,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  srfw_pkg::t_out  i_out,
    output int              o_fail_count,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import srfw_pkg::*;

    localparam int DEPTH = RING_DEPTH_DEF;

    // predicted ring and waiter state
    logic [7:0] ring_bytes [DEPTH];
    int         wr_idx;
    int         rd_idx;
    int         level;
    logic       armed;
    logic [8:0] arm_size;
    logic [7:0] arm_char;

    t_out awaited_results [$];
    int   fail_count = 0;
    int   result_idx = 0;

    assign o_fail_count = fail_count;

    function automatic void clear_waiter();
        armed    = 1'b0;
        arm_size = '0;
        arm_char = '0;
    endfunction

    // apply one request to the predicted state and return its result
    function automatic t_out next_fifo_result(t_in req);
        t_out       res;
        logic [7:0] ch;
        res = '0;
        ch  = (req.rx_byte == CHAR_CR) ? CHAR_LF : req.rx_byte;
        case (req.kind)
            KIND_RX: begin
                if (req.rx_byte != 8'h00) begin
                    if (level >= DEPTH) begin
                        res.dropped = 1'b1;
                    end else begin
                        ring_bytes[wr_idx] = ch;
                        wr_idx = (wr_idx == DEPTH - 1) ? 0 : wr_idx + 1;
                        level++;
                    end
                    // armed waiter echoes, then fires on match before threshold
                    if (armed) begin
                        res.echo_valid = 1'b1;
                        res.echo_byte  = ch;
                        if (arm_char != 8'h00 && ch == arm_char) begin
                            res.notify       = 1'b1;
                            res.notify_count = 9'(level);
                            res.notify_char  = arm_char;
                            clear_waiter();
                        end else if (level >= arm_size) begin
                            res.notify       = 1'b1;
                            res.notify_count = 9'(level);
                            clear_waiter();
                        end
                    end
                end
            end
            KIND_ARM: begin
                if (req.wait_size != '0) begin
                    armed    = 1'b1;
                    arm_size = req.wait_size;
                    arm_char = req.wait_char;
                end else begin
                    clear_waiter();
                end
            end
            KIND_READ: begin
                if (level != 0) begin
                    res.read_valid = 1'b1;
                    res.read_byte  = ring_bytes[rd_idx];
                    rd_idx = (rd_idx == DEPTH - 1) ? 0 : rd_idx + 1;
                    level--;
                end
            end
            default: ;
        endcase
        res.fill_count = 9'(level);
        return res;
    endfunction

    function automatic string show_result(t_out r);
        return $sformatf("echo=%b/%h notify=%b/%0d/%h read=%b/%h fill=%0d drop=%b",
                         r.echo_valid, r.echo_byte, r.notify, r.notify_count,
                         r.notify_char, r.read_valid, r.read_byte, r.fill_count,
                         r.dropped);
    endfunction

    // names of the fields that differ, empty when all agree
    function automatic string field_diff(t_out want, t_out got);
        string s = "";
        if (got.echo_valid !== want.echo_valid)     s = {s, " echo_valid"};
        if (got.echo_byte !== want.echo_byte)       s = {s, " echo_byte"};
        if (got.notify !== want.notify)             s = {s, " notify"};
        if (got.notify_count !== want.notify_count) s = {s, " notify_count"};
        if (got.notify_char !== want.notify_char)   s = {s, " notify_char"};
        if (got.read_valid !== want.read_valid)     s = {s, " read_valid"};
        if (got.read_byte !== want.read_byte)       s = {s, " read_byte"};
        if (got.fill_count !== want.fill_count)     s = {s, " fill_count"};
        if (got.dropped !== want.dropped)           s = {s, " dropped"};
        return s;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%t: %s", $realtime, msg);
        end
    endfunction

    // results are taken before requests so a same-edge request is not matched
    always @(posedge i_clk) begin
        t_out  want;
        string bad;
        if (!i_rst_n) begin
            wr_idx = 0;
            rd_idx = 0;
            level  = 0;
            clear_waiter();
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    note_failure($sformatf("result %0d with no request outstanding: %s",
                                           result_idx, show_result(i_out)));
                end else begin
                    want = awaited_results.pop_front();
                    bad  = field_diff(want, i_out);
                    if (bad != "") begin
                        note_failure($sformatf("result %0d wrong%s: expected %s got %s",
                                               result_idx, bad, show_result(want),
                                               show_result(i_out)));
                    end
                end
                result_idx++;
            end
            if (i_in_valid && i_in_ready) begin
                awaited_results.push_back(next_fifo_result(i_in));
            end
        end
        o_pending <= awaited_results.size();
    end

endmodule

// ===== dv/tb_serial_rx_fifo_with_waiter_unit.sv =====
// top of the serial receive fifo testbench: clock, reset, requests and verdict
// depends on srfw_pkg, serial_rx_fifo_with_waiter_unit and srfw_result_checker
module tb_serial_rx_fifo_with_waiter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import srfw_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int TOTAL_ITEMS = 1920;
    localparam int PHASE_ITEMS = TOTAL_ITEMS / 3;
    localparam int STALL_LIMIT = 4000;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_in   i_in;
    logic  o_out_valid;
    logic  i_out_ready;
    t_out  o_out;

    int         fail_count;
    int         pending;
    int         sent_count = 0;
    int         idle_pct = 29;
    int         stall_pct = 54;
    int         quiet_cycles = 0;
    logic [7:0] last_char = 8'h41;

    serial_rx_fifo_with_waiter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    srfw_result_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
    end
    always #6 i_clk = ~i_clk;

    // result-side backpressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_serial_rx_fifo_with_waiter_unit: done, errors");
                $finish;
            end
        end
    end

    // drive one request, called and returning at a falling edge
    task automatic send_req(input t_in req);
        if (sent_count < PHASE_ITEMS) begin
            idle_pct  = 29;
            stall_pct = 54;
        end else if (sent_count < 2 * PHASE_ITEMS) begin
            idle_pct  = 54;
            stall_pct = 29;
        end else begin
            idle_pct  = 0;
            stall_pct = 0;
        end
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        @(negedge i_clk);
        if (req.kind == KIND_ARM && req.wait_char != 8'h00) begin
            last_char = req.wait_char;
        end
        sent_count++;
    endtask

    task automatic send_fields(input logic [1:0] kind, input logic [7:0] rx,
                               input logic [8:0] size, input logic [7:0] ch);
        t_in req;
        req.kind      = kind;
        req.rx_byte   = rx;
        req.wait_size = size;
        req.wait_char = ch;
        send_req(req);
    endtask

    // random request with the given receive and arm shares, reads taking most of the rest
    function automatic t_in rand_req(int rx_pct, int arm_pct);
        t_in req;
        int  pick;
        req  = t_in'($urandom);
        pick = $urandom_range(99);
        if (pick < rx_pct) begin
            req.kind = KIND_RX;
        end else if (pick < rx_pct + arm_pct) begin
            req.kind = KIND_ARM;
        end else if (pick < 98) begin
            req.kind = KIND_READ;
        end else begin
            req.kind = KIND_UNUSED;
        end
        pick = $urandom_range(99);
        if (pick < 4) begin
            req.rx_byte = 8'h00;
        end else if (pick < 10) begin
            req.rx_byte = CHAR_CR;
        end else if (pick < 20) begin
            req.rx_byte = last_char;
        end
        pick = $urandom_range(99);
        if (pick < 5) begin
            req.wait_size = '0;
        end else if (pick < 15) begin
            req.wait_size = 9'($urandom_range(256, 511));
        end else if (pick < 35) begin
            req.wait_size = 9'($urandom_range(200, 256));
        end else begin
            req.wait_size = 9'($urandom_range(1, 48));
        end
        if ($urandom_range(99) < 30) begin
            req.wait_char = 8'h00;
        end
        return req;
    endfunction

    initial begin
        int seg;
        int len;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_ready = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty read, ignored items, match and threshold firing
        send_fields(KIND_READ, 8'h00, 9'd0, 8'h00);
        send_fields(KIND_RX, 8'h00, 9'd0, 8'h00);
        send_fields(KIND_UNUSED, 8'hFF, 9'h1FF, 8'hFF);
        send_fields(KIND_ARM, 8'h00, 9'd0, 8'h55);
        send_fields(KIND_RX, 8'h41, 9'd0, 8'h00);
        send_fields(KIND_ARM, 8'h00, 9'd3, 8'h42);
        send_fields(KIND_RX, CHAR_CR, 9'd0, 8'h00);
        send_fields(KIND_RX, 8'h42, 9'd0, 8'h00);
        // threshold above capacity with a CR match that can never hit
        send_fields(KIND_ARM, 8'h00, 9'h1FF, CHAR_CR);
        send_fields(KIND_RX, CHAR_CR, 9'd0, 8'h00);
        send_fields(KIND_RX, 8'hFF, 9'd0, 8'h00);
        send_fields(KIND_ARM, 8'h00, 9'd256, 8'hFF);
        send_fields(KIND_RX, 8'hFF, 9'd0, 8'h00);
        send_fields(KIND_ARM, 8'h00, 9'd5, 8'h00);
        send_fields(KIND_RX, 8'h7F, 9'd0, 8'h00);
        send_fields(KIND_READ, 8'h00, 9'd0, 8'h00);
        send_fields(KIND_READ, 8'h00, 9'd0, 8'h00);
        send_fields(KIND_ARM, 8'h00, 9'd1, CHAR_LF);
        send_fields(KIND_RX, CHAR_CR, 9'd0, 8'h00);
        send_fields(KIND_READ, 8'h00, 9'd0, 8'h00);

        // random segments: fill bursts to overflow, drains to empty, waiter sequences
        while (sent_count < TOTAL_ITEMS) begin
            seg = $urandom_range(9);
            if (seg < 2) begin
                len = $urandom_range(260, 300);
                if (len > TOTAL_ITEMS - sent_count) len = TOTAL_ITEMS - sent_count;
                repeat (len) send_req(rand_req(94, 3));
            end else if (seg < 4) begin
                len = $urandom_range(100, 300);
                if (len > TOTAL_ITEMS - sent_count) len = TOTAL_ITEMS - sent_count;
                repeat (len) send_req(rand_req(5, 3));
            end else begin
                send_req(rand_req(0, 100));
                len = $urandom_range(3, 40);
                if (len > TOTAL_ITEMS - sent_count) len = TOTAL_ITEMS - sent_count;
                repeat (len) send_req(rand_req(80, 2));
            end
        end
        i_in_valid <= 1'b0;
        stall_pct = 0;

        // drain outstanding results, then let the block idle before the verdict
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_serial_rx_fifo_with_waiter_unit: done, clean");
        end else begin
            $display("tb_serial_rx_fifo_with_waiter_unit: done, errors");
        end
        $finish;
    end

endmodule
